// ===== hdl/integer_pixel_upscaler_defines.svh =====
// Assertion macros shared by the upscaler RTL.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef INTEGER_PIXEL_UPSCALER_DEFINES_SVH
`define INTEGER_PIXEL_UPSCALER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IPU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IPU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ipu_pkg.sv =====
// Package for the integer pixel upscaler: field widths, scale codes, queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package ipu_pkg;

    localparam int ADDR_W  = 21;
    localparam int DATA_W  = 32;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int SCALE_W = 3;
    localparam int STEP_W  = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 3'd2;
    localparam logic [SCALE_W-1:0] SCALE_X2    = 3'd2;
    localparam logic [SCALE_W-1:0] SCALE_X3    = 3'd3;
    localparam logic [SCALE_W-1:0] SCALE_X4    = 3'd4;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // One source pixel, ready for expansion.
    typedef struct packed {
        logic [ADDR_W-1:0]  base;   // address of the top-left destination write
        logic [DATA_W-1:0]  pixel;  // masked pixel value
        logic [SCALE_W-1:0] scale;  // 2, 3 or 4
    } ipu_entry_t;

endpackage

// ===== hdl/ipu_front.sv =====
// Front end: accepts source pixels, tracks column/row, computes the base address.
// Depends on ipu_pkg and integer_pixel_upscaler_defines.svh.
`timescale 1ns / 1ps
`include "integer_pixel_upscaler_defines.svh"

module ipu_front
    import ipu_pkg::*;
#(
    parameter int SRC_WIDTH  = 320,
    parameter int SRC_HEIGHT = 240,
    parameter int PIXEL_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,
    input  logic               s_tuser,
    input  logic [SCALE_W-1:0] scale_factor,
    input  logic               fifo_full,
    output logic               push,
    output ipu_entry_t         push_entry
);

    // Vertical stride of one source row in the destination: SRC_WIDTH * s * s.
    localparam logic [ADDR_W-1:0] ROW_STEP_X2 = ADDR_W'(SRC_WIDTH * 4);
    localparam logic [ADDR_W-1:0] ROW_STEP_X3 = ADDR_W'(SRC_WIDTH * 9);
    localparam logic [ADDR_W-1:0] ROW_STEP_X4 = ADDR_W'(SRC_WIDTH * 16);
    localparam logic [DATA_W-1:0] PIX_MASK    = DATA_W'((64'd1 << PIXEL_BITS) - 64'd1);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_eff, col_inc;
    logic [ROW_W-1:0]  row_eff, row_inc;
    logic [ADDR_W-1:0] row_step, col_term, row_term;
    logic              scale_ok, accept;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;

    assign col_eff = s_tuser ? '0 : col_reg;
    assign row_eff = s_tuser ? '0 : row_reg;

    always_comb begin
        scale_ok = 1'b1;
        row_step = ROW_STEP_X4;
        col_term = '0;
        unique case (scale_factor)
            SCALE_X2: begin
                row_step = ROW_STEP_X2;
                col_term = ADDR_W'({col_eff, 1'b0});
            end
            SCALE_X3: begin
                row_step = ROW_STEP_X3;
                col_term = ADDR_W'({col_eff, 1'b0}) + ADDR_W'(col_eff);
            end
            SCALE_X4: begin
                row_step = ROW_STEP_X4;
                col_term = ADDR_W'({col_eff, 2'b00});
            end
            default: begin
                scale_ok = 1'b0;
            end
        endcase
    end

    assign row_term = ADDR_W'(row_eff) * row_step;

    assign push             = accept && scale_ok;
    assign push_entry.base  = row_term + col_term;
    assign push_entry.pixel = s_tdata & PIX_MASK;
    assign push_entry.scale = scale_factor;

    // Raster position advance; the column counter also wraps at its own width.
    always_comb begin
        col_inc  = col_eff + COL_W'(1);
        row_inc  = row_eff + ROW_W'(1);
        col_next = col_inc;
        row_next = row_eff;
        if ((col_inc == '0) || (32'(col_inc) >= SRC_WIDTH)) begin
            col_next = '0;
            row_next = (32'(row_inc) >= SRC_HEIGHT) ? '0 : row_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    `IPU_ASSERT_NOW(a_frame_start_base, aclk, aresetn, push && s_tuser,
                    push_entry.base == '0, "frame start pixel must map to address zero")
    `IPU_ASSERT_NOW(a_no_accept_full, aclk, aresetn, fifo_full, !accept,
                    "pixel accepted while queue full")

endmodule

// ===== hdl/ipu_fifo.sv =====
// Small queue of pending pixel entries between front and back ends.
// Depends on ipu_pkg and integer_pixel_upscaler_defines.svh.
`timescale 1ns / 1ps
`include "integer_pixel_upscaler_defines.svh"

module ipu_fifo
    import ipu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  ipu_entry_t push_entry,
    input  logic       pop,
    output ipu_entry_t head,
    output logic       empty,
    output logic       full
);

    ipu_entry_t       entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == FIFO_DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == FIFO_DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `IPU_ASSERT_NOW(a_no_overflow, aclk, aresetn, full, !push, "queue overflow")
    `IPU_ASSERT_NOW(a_no_underflow, aclk, aresetn, empty, !pop, "queue underflow")

endmodule

// ===== hdl/ipu_back.sv =====
// Back end: expands each queued pixel into s*s destination writes, dy outer, dx inner.
// Depends on ipu_pkg and integer_pixel_upscaler_defines.svh.
`timescale 1ns / 1ps
`include "integer_pixel_upscaler_defines.svh"

module ipu_back
    import ipu_pkg::*;
#(
    parameter int SRC_WIDTH = 320
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ipu_entry_t            head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [ADDR_W-1:0]     m_addr,
    output logic [DATA_W-1:0]     m_pixel,
    output logic                  m_tlast
);

    localparam logic [ADDR_W-1:0] LINE_X2 = ADDR_W'(SRC_WIDTH * 2);
    localparam logic [ADDR_W-1:0] LINE_X3 = ADDR_W'(SRC_WIDTH * 3);
    localparam logic [ADDR_W-1:0] LINE_X4 = ADDR_W'(SRC_WIDTH * 4);

    logic [STEP_W-1:0] dx_reg, dx_next;
    logic [STEP_W-1:0] dy_reg, dy_next;
    logic [ADDR_W-1:0] line_off_reg, line_off_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [DATA_W-1:0] m_pixel_reg, m_pixel_next;
    logic              m_tlast_reg, m_tlast_next;
    logic [ADDR_W-1:0] line;
    logic              out_free, emit, dx_end, dy_end;

    always_comb begin
        unique case (head.scale)
            SCALE_X2: line = LINE_X2;
            SCALE_X3: line = LINE_X3;
            default:  line = LINE_X4;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = !empty && out_free;
    assign dx_end   = ({1'b0, dx_reg} == head.scale - SCALE_W'(1));
    assign dy_end   = ({1'b0, dy_reg} == head.scale - SCALE_W'(1));
    assign pop      = emit && dx_end && dy_end;

    always_comb begin
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        line_off_next = line_off_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_addr_next   = m_addr_reg;
        m_pixel_next  = m_pixel_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_addr_next   = head.base + line_off_reg + ADDR_W'(dx_reg);
            m_pixel_next  = head.pixel;
            m_tlast_next  = dx_end && dy_end;
            if (dx_end) begin
                dx_next = '0;
                if (dy_end) begin
                    dy_next       = '0;
                    line_off_next = '0;
                end else begin
                    dy_next       = dy_reg + STEP_W'(1);
                    line_off_next = line_off_reg + line;
                end
            end else begin
                dx_next = dx_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dx_reg       <= '0;
            dy_reg       <= '0;
            line_off_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            line_off_reg <= line_off_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_addr_reg  <= m_addr_next;
        m_pixel_reg <= m_pixel_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_addr   = m_addr_reg;
    assign m_pixel  = m_pixel_reg;
    assign m_tlast  = m_tlast_reg;

    `IPU_ASSERT_NEXT(a_pop_rewinds, aclk, aresetn, pop, (dx_reg == '0) && (dy_reg == '0) && (line_off_reg == '0), "counters not rewound after last write")
    `IPU_ASSERT_NOW(a_idle_counters, aclk, aresetn, empty, (dx_reg == '0) && (dy_reg == '0), "expansion counters moved with no pixel queued")

endmodule

// ===== hdl/integer_pixel_upscaler.sv =====
// Path: a pixel's first write is registered in the queue and then in the output register.
// Throughput: s*s writes per source pixel (4, 9 or 16), one destination write per cycle
// while m_tready accepts, from the back-end generator; a 4-entry queue decouples the ends.
// Reset: synchronous, active-low aresetn; clears position, queue, counters, output valid,
// and sets scale_factor to 2.
`timescale 1ns / 1ps

module integer_pixel_upscaler
    import ipu_pkg::*;
#(
    parameter int SRC_WIDTH  = 320,
    parameter int SRC_HEIGHT = 240,
    parameter int PIXEL_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration: scale factor, written while the block is idle.
    input  logic               scale_factor_wr_en,
    input  logic [SCALE_W-1:0] scale_factor_wr_data,
    // Source pixel stream.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // [31:0] pixel_value
    input  logic               s_tuser,   // [0] frame_start
    // Destination write stream.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata,   // [20:0] dest_address, [52:21] dest_pixel, [55:53] zero
    output logic               m_tlast    // last_write
);

    logic [SCALE_W-1:0] scale_factor_reg;

    // Front/queue/back interconnect.
    ipu_entry_t        push_entry, head;
    logic              push, pop, fifo_empty, fifo_full;
    logic [ADDR_W-1:0] m_addr;
    logic [DATA_W-1:0] m_pixel;

    // Scale register; an unsupported value makes the front end drop pixels after
    // advancing the position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_factor_reg <= SCALE_RESET;
        end else if (scale_factor_wr_en) begin
            scale_factor_reg <= scale_factor_wr_data;
        end
    end

    // Front end: one transaction per cycle while the queue has room.
    ipu_front #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .scale_factor (scale_factor_reg),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    // Pending pixels with precomputed base addresses.
    ipu_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (fifo_empty),
        .full       (fifo_full)
    );

    // Back end: walks dy/dx over the head entry into the output register.
    ipu_back #(
        .SRC_WIDTH (SRC_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (fifo_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_addr   (m_addr),
        .m_pixel  (m_pixel),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = {3'b000, m_pixel, m_addr};

endmodule

// ===== tb/ipu_write_checker.sv =====
// Checker for the integer pixel upscaler: tracks scale and source position, predicts the
// destination writes of every source pixel and compares them in order. Needs ipu_pkg.
`timescale 1ns / 1ps

module ipu_write_checker
    import ipu_pkg::*;
#(
    parameter int SRC_WIDTH  = 320,
    parameter int SRC_HEIGHT = 240,
    parameter int PIXEL_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               scale_factor_wr_en,
    input  logic [SCALE_W-1:0] scale_factor_wr_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [31:0]        s_tdata,   // [31:0] pixel_value
    input  logic               s_tuser,   // [0] frame_start
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [55:0]        m_tdata,   // [20:0] dest_address, [52:21] dest_pixel
    input  logic               m_tlast,   // last_write
    output int                 mismatches,
    output int                 writes_due
);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] pixel;
        logic              last;
    } dest_write_t;

    dest_write_t        due_writes[$];
    logic [SCALE_W-1:0] scale;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    int                 errors = 0;

    // Expand one source pixel into its s*s writes, then step the raster position.
    function automatic void expand_pixel(logic [31:0] value, logic frame_start);
        logic [DATA_W-1:0] pix;
        logic [COL_W-1:0]  next_col;
        logic [ROW_W-1:0]  next_row;
        longint            s;
        longint            a;
        dest_write_t       w;
        pix = value & DATA_W'((64'd1 << PIXEL_BITS) - 64'd1);
        if (frame_start) begin
            column = '0;
            row    = '0;
        end
        s = longint'(scale);
        if (s >= 2 && s <= 4) begin
            for (longint dy = 0; dy < s; dy++) begin
                for (longint dx = 0; dx < s; dx++) begin
                    a = (longint'(row) * s + dy) * (SRC_WIDTH * s) + longint'(column) * s + dx;
                    w.addr  = ADDR_W'(a);
                    w.pixel = pix;
                    w.last  = (dy == s - 1) && (dx == s - 1);
                    due_writes.push_back(w);
                end
            end
        end
        // unsupported scales still move the position
        next_col = column + 1'b1;
        if (next_col >= SRC_WIDTH || next_col == '0) begin
            next_row = row + 1'b1;
            if (next_row >= SRC_HEIGHT)
                next_row = '0;
            row      = next_row;
            next_col = '0;
        end
        column = next_col;
    endfunction

    function automatic void check_write();
        dest_write_t exp_w;
        if (due_writes.size() == 0) begin
            $display("%0t: unexpected write addr=%0d pixel=%h last=%b", $time,
                     m_tdata[20:0], m_tdata[52:21], m_tlast);
            errors++;
            return;
        end
        exp_w = due_writes.pop_front();
        if (m_tdata[20:0] !== exp_w.addr) begin
            $display("%0t: dest_address expected %0d actual %0d", $time,
                     exp_w.addr, m_tdata[20:0]);
            errors++;
        end
        if (m_tdata[52:21] !== exp_w.pixel) begin
            $display("%0t: dest_pixel expected %h actual %h", $time,
                     exp_w.pixel, m_tdata[52:21]);
            errors++;
        end
        if (m_tlast !== exp_w.last) begin
            $display("%0t: last_write expected %b actual %b", $time, exp_w.last, m_tlast);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            scale  = SCALE_RESET;
            column = '0;
            row    = '0;
            due_writes.delete();
        end else begin
            if (scale_factor_wr_en)
                scale = scale_factor_wr_data;
            // output first: a write can never belong to a pixel taken at the same edge
            if (m_tvalid && m_tready)
                check_write();
            if (s_tvalid && s_tready)
                expand_pixel(s_tdata, s_tuser);
        end
        mismatches <= errors;
        writes_due <= due_writes.size();
    end

endmodule

// ===== tb/tb_integer_pixel_upscaler.sv =====
// Top of the upscaler testbench: clock, reset, pixel source, write sink, watchdog, verdict.
// Depends on ipu_pkg, integer_pixel_upscaler and ipu_write_checker.
`timescale 1ns / 1ps

module tb_integer_pixel_upscaler;
    import ipu_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 2;
    localparam int GAP_MAX       = 6;     // per-transaction idle on either side
    localparam int HOLD_CYCLES   = 400;   // long sink back-pressure stretch
    localparam int DRAIN_CYCLES  = 20;    // settle time after the last write
    localparam int STALL_LIMIT   = 5000;  // cycles without any transaction
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 8;
    localparam int SRC_W         = 320;
    localparam int SRC_H         = 240;

    // Scale codes the block refuses: a pixel still moves the position but writes nothing.
    localparam logic [SCALE_W-1:0] UNSUPPORTED_SCALES[5] = '{3'd0, 3'd1, 3'd5, 3'd6, 3'd7};

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               scale_wr_en   = 1'b0;
    logic [SCALE_W-1:0] scale_wr_data = SCALE_RESET;
    logic               s_tvalid  = 1'b0;
    logic [31:0]        s_tdata   = '0;
    logic               s_tuser   = 1'b0;
    logic               m_tready  = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [55:0]        m_tdata;
    logic               m_tlast;

    int mismatches;
    int writes_due;
    int quiet_cycles = 0;
    bit steady   = 1'b0;  // when set neither side inserts idle cycles
    bit hold_req = 1'b0;  // asks the sink for one long back-pressure stretch

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
    end

    integer_pixel_upscaler #(
        .SRC_WIDTH  (SRC_W),
        .SRC_HEIGHT (SRC_H),
        .PIXEL_BITS (32)
    ) DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .scale_factor_wr_en   (scale_wr_en),
        .scale_factor_wr_data (scale_wr_data),
        .s_tvalid             (s_tvalid),
        .s_tready             (s_tready),
        .s_tdata              (s_tdata),
        .s_tuser              (s_tuser),
        .m_tvalid             (m_tvalid),
        .m_tready             (m_tready),
        .m_tdata              (m_tdata),
        .m_tlast              (m_tlast)
    );

    ipu_write_checker #(
        .SRC_WIDTH  (SRC_W),
        .SRC_HEIGHT (SRC_H),
        .PIXEL_BITS (32)
    ) u_write_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .scale_factor_wr_en   (scale_wr_en),
        .scale_factor_wr_data (scale_wr_data),
        .s_tvalid             (s_tvalid),
        .s_tready             (s_tready),
        .s_tdata              (s_tdata),
        .s_tuser              (s_tuser),
        .m_tvalid             (m_tvalid),
        .m_tready             (m_tready),
        .m_tdata              (m_tdata),
        .m_tlast              (m_tlast),
        .mismatches           (mismatches),
        .writes_due           (writes_due)
    );

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Write sink. Draws a stall before every transaction; once per hold_req it keeps
    // tready low for a long stretch so the internal queue fills and s_tready drops.
    initial begin : write_sink
        int stall;
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = steady ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // One pixel transaction. tvalid stays high across back-to-back pixels.
    task automatic send_pixel(input logic [31:0] value, input logic frame_start);
        int gap;
        gap = steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= frame_start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering pixels and wait until every predicted write has come out, plus
    // a margin for a pixel that produces no writes but may still be in flight.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (writes_due != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        drain();
        scale_wr_en   <= 1'b1;
        scale_wr_data <= value;
        @(posedge aclk);
        scale_wr_en   <= 1'b0;
    endtask

    function automatic logic [31:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [SCALE_W-1:0] sc;
        @(posedge aclk iff aresetn);

        // Directed: reset scale (x2), data extremes, frame restart mid-stream.
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h8000_0000, 1'b0);
        send_pixel(32'h0000_0001, 1'b0);
        send_pixel(32'hAAAA_AAAA, 1'b0);
        send_pixel(32'h5555_5555, 1'b1);

        write_scale(SCALE_X3);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);

        write_scale(SCALE_X4);
        send_pixel(32'hDEAD_BEEF, 1'b0);
        send_pixel(32'h0F0F_F0F0, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);

        // Every refused scale code: no writes, position keeps counting.
        foreach (UNSUPPORTED_SCALES[i]) begin
            write_scale(UNSUPPORTED_SCALES[i]);
            send_pixel($urandom, 1'b0);
        end
        write_scale(SCALE_X2);
        send_pixel(32'hCAFE_F00D, 1'b0);
        send_pixel(32'h0000_FFFF, 1'b0);

        // Position sweep. A refused scale advances the raster quickly without writes,
        // so the end of a line is reached cheaply.
        steady = 1'b1;
        write_scale(UNSUPPORTED_SCALES[0]);
        send_pixel($urandom, 1'b1);
        repeat (SRC_W - 2) send_pixel($urandom, 1'b0);
        // next pixel sits in the last column of row 0: line wrap at x4
        write_scale(SCALE_X4);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        steady = 1'b0;

        // Random phases: scale rotates through 2/4/3, every fourth phase picks any
        // code including refused ones. Some phases run without idles, one holds the sink.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p % 4 == 0)
                sc = SCALE_X2;
            else if (p % 4 == 1)
                sc = SCALE_X4;
            else if (p % 4 == 2)
                sc = SCALE_X3;
            else if ($urandom_range(0, 3) == 0)
                sc = UNSUPPORTED_SCALES[$urandom_range(0, 4)];
            else
                sc = SCALE_X2 + SCALE_W'($urandom_range(0, 2));
            write_scale(sc);
            steady = (p == 3) || (p == 6);
            if (p == 5)
                hold_req <= 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_pixel(random_pixel(), $urandom_range(0, 15) == 0);
        end
        steady = 1'b0;

        drain();
        if (mismatches == 0 && writes_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ipu_pkg.sv
hdl/ipu_front.sv
hdl/ipu_fifo.sv
hdl/ipu_back.sv
hdl/integer_pixel_upscaler.sv
tb/ipu_write_checker.sv
tb/tb_integer_pixel_upscaler.sv
